// File: hdl/hsc_pkg.sv
// Constants, types and small helpers for the HLS shade color pipeline.
// Used by hls_shade_color and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package hsc_pkg;

  localparam int unsigned CHAN_W = 16;
  localparam logic [CHAN_W-1:0] FULL_SCALE = {CHAN_W{1'b1}};

  // Q9.8 hue angles
  localparam logic [16:0] DEG60  = 17'd15360;
  localparam logic [16:0] DEG120 = 17'd30720;
  localparam logic [16:0] DEG180 = 17'd46080;
  localparam logic [16:0] DEG240 = 17'd61440;
  localparam logic [16:0] DEG360 = 17'd92160;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // restoring divider: one quotient bit per stage
  localparam int unsigned DIV_STAGES = 18;
  localparam int unsigned REM_W      = 36;

  // two front stages, divider, seven back stages
  localparam int unsigned PIPE_LAT = 2 + DIV_STAGES + 7;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_SHADE_FACTOR = 1'b0;
  localparam logic [15:0] SHADE_RESET = 16'd4096;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } hsc_max_e;

  // Q1.16 value times Q4.12 factor, rounded and clamped to 1.0
  function automatic logic [16:0] scale_round(input logic [32:0] prod);
    logic [33:0] rnd;
    logic [21:0] shr;
    begin
      rnd = {1'b0, prod} + 34'd2048;
      shr = rnd[33:12];
      scale_round = (shr > {5'd0, ONE_Q16}) ? ONE_Q16 : shr[16:0];
    end
  endfunction

  // weight of (m2-m1) along the hue ramp, 0..DEG60
  function automatic logic [13:0] ramp_weight(input logic [16:0] x);
    logic [16:0] diff;
    begin
      diff = DEG240 - x;
      if (x < DEG60) begin
        ramp_weight = x[13:0];
      end else if (x < DEG180) begin
        ramp_weight = DEG60[13:0];
      end else if (x < DEG240) begin
        ramp_weight = diff[13:0];
      end else begin
        ramp_weight = 14'd0;
      end
    end
  endfunction

  // hue offset by a constant angle, wrapped into [0, 360)
  function automatic logic [16:0] hue_add(input logic [16:0] h, input logic [16:0] ofs);
    logic [17:0] s;
    begin
      s = {1'b0, h} + {1'b0, ofs};
      hue_add = (s >= {1'b0, DEG360}) ? 17'(s - {1'b0, DEG360}) : s[16:0];
    end
  endfunction

endpackage

// File: hdl/hls_shade_color.sv
// HLS shade color: RGB to hue/lightness/saturation, scale L and S, back to RGB.
// Depends on hsc_pkg.
`timescale 1ns / 1ps

// One pixel is taken per clock whenever start is high; busy never rises. Each
// pixel comes out at the end of the pipeline, marked by done for one cycle,
// in input order. The pipeline holds the saturation and hue divisions, which
// run as an 18-stage restoring divider (one quotient bit per stage), plus two
// front stages and seven back stages for scaling, the m1/m2 terms and the
// three channel ramps. shade_factor (APB address 0) should only be written
// while no pixel is in flight.
module hls_shade_color (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [hsc_pkg::CHAN_W-1:0]  in_red_i,
  input  logic [hsc_pkg::CHAN_W-1:0]  in_green_i,
  input  logic [hsc_pkg::CHAN_W-1:0]  in_blue_i,
  output logic                        done,
  output logic [hsc_pkg::CHAN_W-1:0]  out_red_o,
  output logic [hsc_pkg::CHAN_W-1:0]  out_green_o,
  output logic [hsc_pkg::CHAN_W-1:0]  out_blue_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hsc_pkg::*;

  // ---------------------------------------------------------------- config
  logic [15:0] shade_q;
  logic        reg_hit;

  assign reg_hit = (paddr[ADDR_W-1:2] == REG_SHADE_FACTOR);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {16'd0, shade_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shade_q <= SHADE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      shade_q <= pwdata[15:0];
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage A
  logic [15:0] r, g, b, mx, mn, d;
  logic [16:0] sum, den;
  logic [19:0] t, d20;
  hsc_max_e    sel;

  always_comb begin
    r = (in_red_i   > FULL_SCALE) ? FULL_SCALE : in_red_i;
    g = (in_green_i > FULL_SCALE) ? FULL_SCALE : in_green_i;
    b = (in_blue_i  > FULL_SCALE) ? FULL_SCALE : in_blue_i;
    // red wins ties over green, green over blue
    if (r >= g && r >= b) begin
      sel = MAX_RED;
      mx  = r;
    end else if (g >= b) begin
      sel = MAX_GREEN;
      mx  = g;
    end else begin
      sel = MAX_BLUE;
      mx  = b;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum <= {1'b0, FULL_SCALE}) ? sum : 17'({FULL_SCALE, 1'b0} - sum);
    d20 = {4'd0, d};
    // (sextant + 6) * d + diff, never negative
    case (sel)
      MAX_RED:   t = (d20 << 2) + (d20 << 1) + {4'd0, g} - {4'd0, b};
      MAX_GREEN: t = (d20 << 3) + {4'd0, b} - {4'd0, r};
      MAX_BLUE:  t = (d20 << 3) + (d20 << 1) + {4'd0, r} - {4'd0, g};
      default:   t = 20'd0;
    endcase
  end

  logic        a_valid_q;
  logic [19:0] a_t_q;
  logic [15:0] a_d_q;
  logic [16:0] a_den_q, a_sum_q;
  logic        a_gray_q;

  always_ff @(posedge clk_i) begin
    a_t_q    <= t;
    a_d_q    <= d;
    a_den_q  <= den;
    a_sum_q  <= sum;
    a_gray_q <= (mx == mn);
  end

  // ---------------------------------------------------------------- stage B
  // dividend/divisor pairs for round(num/den) = floor((2num+den)/(2den))
  logic [REM_W-1:0] nh, ns;
  logic [17:0]      dh, ds;
  logic [31:0]      lq_m;
  logic [16:0]      lq_c, lq;

  always_comb begin
    nh = ({16'd0, a_t_q} << 15) - ({16'd0, a_t_q} << 11) + {20'd0, a_d_q};
    ns = {3'd0, a_d_q, 17'd0} + {19'd0, a_den_q};
    dh = {1'b0, a_d_q, 1'b0};
    ds = {a_den_q, 1'b0};
    if (a_gray_q) begin
      nh = '0;
      ns = '0;
      dh = 18'd1;
      ds = 18'd1;
    end
    // lightness: floor((sum*32768 + 32767) / 65535) by fold of 2^16 - 1
    lq_m = {a_sum_q[16:0], 15'h7fff};
    lq_c = {1'b0, lq_m[31:16]} + {1'b0, lq_m[15:0]};
    lq   = {1'b0, lq_m[31:16]} + 17'(lq_c >= 17'd65535) + 17'(lq_c >= 17'd131070);
  end

  logic                  b_valid_q;
  logic [REM_W-1:0]      b_nh_q, b_ns_q;
  logic [17:0]           b_dh_q, b_ds_q;
  logic [16:0]           b_lq_q;

  always_ff @(posedge clk_i) begin
    b_nh_q <= nh;
    b_ns_q <= ns;
    b_dh_q <= dh;
    b_ds_q <= ds;
    b_lq_q <= lq;
  end

  // ---------------------------------------------------------------- divider
  logic                  dv_valid_q [DIV_STAGES];
  logic [REM_W-1:0]      dv_rh_q    [DIV_STAGES];
  logic [REM_W-1:0]      dv_rs_q    [DIV_STAGES];
  logic [17:0]           dv_dh_q    [DIV_STAGES];
  logic [17:0]           dv_ds_q    [DIV_STAGES];
  logic [17:0]           dv_qh_q    [DIV_STAGES];
  logic [17:0]           dv_qs_q    [DIV_STAGES];
  logic [16:0]           dv_lq_q    [DIV_STAGES];

  logic [REM_W-1:0]      rh_in [DIV_STAGES];
  logic [REM_W-1:0]      rs_in [DIV_STAGES];
  logic [17:0]           dh_in [DIV_STAGES];
  logic [17:0]           ds_in [DIV_STAGES];
  logic [17:0]           qh_in [DIV_STAGES];
  logic [17:0]           qs_in [DIV_STAGES];
  logic [16:0]           lq_in [DIV_STAGES];
  logic [REM_W-1:0]      rh_nx [DIV_STAGES];
  logic [REM_W-1:0]      rs_nx [DIV_STAGES];
  logic [17:0]           qh_nx [DIV_STAGES];
  logic [17:0]           qs_nx [DIV_STAGES];

  always_comb begin
    logic [REM_W-1:0] shh, shs;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rh_in[k] = b_nh_q;
        rs_in[k] = b_ns_q;
        dh_in[k] = b_dh_q;
        ds_in[k] = b_ds_q;
        qh_in[k] = '0;
        qs_in[k] = '0;
        lq_in[k] = b_lq_q;
      end else begin
        rh_in[k] = dv_rh_q[k-1];
        rs_in[k] = dv_rs_q[k-1];
        dh_in[k] = dv_dh_q[k-1];
        ds_in[k] = dv_ds_q[k-1];
        qh_in[k] = dv_qh_q[k-1];
        qs_in[k] = dv_qs_q[k-1];
        lq_in[k] = dv_lq_q[k-1];
      end
      shh = {{(REM_W-18){1'b0}}, dh_in[k]} << (DIV_STAGES - 1 - k);
      shs = {{(REM_W-18){1'b0}}, ds_in[k]} << (DIV_STAGES - 1 - k);
      if (rh_in[k] >= shh) begin
        rh_nx[k] = rh_in[k] - shh;
        qh_nx[k] = {qh_in[k][16:0], 1'b1};
      end else begin
        rh_nx[k] = rh_in[k];
        qh_nx[k] = {qh_in[k][16:0], 1'b0};
      end
      if (rs_in[k] >= shs) begin
        rs_nx[k] = rs_in[k] - shs;
        qs_nx[k] = {qs_in[k][16:0], 1'b1};
      end else begin
        rs_nx[k] = rs_in[k];
        qs_nx[k] = {qs_in[k][16:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_rh_q[k] <= rh_nx[k];
      dv_rs_q[k] <= rs_nx[k];
      dv_dh_q[k] <= dh_in[k];
      dv_ds_q[k] <= ds_in[k];
      dv_qh_q[k] <= qh_nx[k];
      dv_qs_q[k] <= qs_nx[k];
      dv_lq_q[k] <= lq_in[k];
    end
  end

  // ---------------------------------------------------------------- back end
  logic [17:0] hq_raw;
  logic [16:0] hq_wrap;

  assign hq_raw  = dv_qh_q[DIV_STAGES-1];
  assign hq_wrap = (hq_raw >= {1'b0, DEG360}) ? 17'(hq_raw - {1'b0, DEG360}) : hq_raw[16:0];

  // C1: scale products
  logic        c1_valid_q;
  logic [16:0] c1_hg_q;
  logic [32:0] c1_pl_q, c1_ps_q;

  // C2: scaled L, S and the three hues
  logic        c2_valid_q;
  logic [16:0] c2_lq_q, c2_sq_q, c2_hr_q, c2_hg_q, c2_hb_q;

  // C3: L*S and ramp weights
  logic        c3_valid_q;
  logic [33:0] c3_ls_q;
  logic [16:0] c3_lq_q, c3_sq_q;
  logic [13:0] c3_w_q [3];

  // C4: ramp base and slope
  logic        c4_valid_q;
  logic [32:0] c4_delta_q;
  logic [45:0] c4_base_q;
  logic [13:0] c4_w_q [3];

  // C5..C6: per-channel products and sums
  logic        c5_valid_q, c6_valid_q;
  logic [46:0] c5_prod_q [3];
  logic [45:0] c5_base_q;
  logic [45:0] c6_acc_q  [3];

  logic [34:0] m2, m1, lq17, lq16, sq16, ls35;
  logic [32:0] m1_t;

  always_comb begin
    lq16 = {2'd0, c3_lq_q, 16'd0};
    lq17 = {1'b0, c3_lq_q, 17'd0};
    sq16 = {2'd0, c3_sq_q, 16'd0};
    ls35 = {1'b0, c3_ls_q};
    if (c3_lq_q <= HALF_Q16) begin
      m2 = lq16 + ls35;
    end else begin
      m2 = lq16 + sq16 - ls35;
    end
    m1   = lq17 - m2;
    m1_t = m1[32:0];
  end

  logic [59:0] y [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // acc * 65535 / (15 * 2^42) == acc * 4369 / 2^42, rounded
      y[c] = {14'd0, c6_acc_q[c]} + ({14'd0, c6_acc_q[c]} << 4)
           + ({14'd0, c6_acc_q[c]} << 8) + ({14'd0, c6_acc_q[c]} << 12)
           + (60'd1 << 41);
    end
  end

  logic        done_q;
  logic [15:0] out_red_q, out_green_q, out_blue_q;

  always_ff @(posedge clk_i) begin
    c1_hg_q <= hq_wrap;
    c1_pl_q <= {16'd0, dv_lq_q[DIV_STAGES-1]} * {17'd0, shade_q};
    c1_ps_q <= {16'd0, dv_qs_q[DIV_STAGES-1][16:0]} * {17'd0, shade_q};

    c2_lq_q <= scale_round(c1_pl_q);
    c2_sq_q <= scale_round(c1_ps_q);
    c2_hg_q <= c1_hg_q;
    c2_hr_q <= hue_add(c1_hg_q, DEG120);
    c2_hb_q <= hue_add(c1_hg_q, DEG240);

    c3_ls_q   <= {17'd0, c2_lq_q} * {17'd0, c2_sq_q};
    c3_lq_q   <= c2_lq_q;
    c3_sq_q   <= c2_sq_q;
    c3_w_q[0] <= ramp_weight(c2_hr_q);
    c3_w_q[1] <= ramp_weight(c2_hg_q);
    c3_w_q[2] <= ramp_weight(c2_hb_q);

    c4_delta_q <= 33'(m2 - m1);
    c4_base_q  <= ({13'd0, m1_t} << 14) - ({13'd0, m1_t} << 10);
    c4_w_q     <= c3_w_q;

    for (int c = 0; c < 3; c++) begin
      c5_prod_q[c] <= {14'd0, c4_delta_q} * {33'd0, c4_w_q[c]};
      c6_acc_q[c]  <= 46'(c5_prod_q[c] + {1'b0, c5_base_q});
    end
    c5_base_q <= c4_base_q;

    out_red_q   <= y[0][57:42];
    out_green_q <= y[1][57:42];
    out_blue_q  <= y[2][57:42];
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_valid_q[k] <= 1'b0;
      end
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
      c3_valid_q <= 1'b0;
      c4_valid_q <= 1'b0;
      c5_valid_q <= 1'b0;
      c6_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_valid_q[k] <= (k == 0) ? b_valid_q : dv_valid_q[(k == 0) ? 0 : k-1];
      end
      c1_valid_q <= dv_valid_q[DIV_STAGES-1];
      c2_valid_q <= c1_valid_q;
      c3_valid_q <= c2_valid_q;
      c4_valid_q <= c3_valid_q;
      c5_valid_q <= c4_valid_q;
      c6_valid_q <= c5_valid_q;
      done_q     <= c6_valid_q;
    end
  end

  assign done        = done_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_LAT done)
    else $error("pixel transfer did not complete after pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(accept, PIPE_LAT))
    else $error("result strobe without a matching input transfer");

  a_gray_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_red_i == in_green_i && in_green_i == in_blue_i) |->
      ##PIPE_LAT (out_red_o == out_green_o && out_green_o == out_blue_o))
    else $error("gray pixel produced unequal channels");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for hls_shade_color: random and directed RGB pixels
// under several shade factors, checked against an in-bench fixed-point predictor.
// Depends on hsc_pkg and hls_shade_color.
`timescale 1ns / 1ps

module tb;
  import hsc_pkg::*;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  localparam logic [63:0] FS     = 64'd65535;
  localparam int unsigned LIMIT  = 3000;
  localparam int unsigned DRAIN  = PIPE_LAT + 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_red_i = '0, in_green_i = '0, in_blue_i = '0;
  logic        done;
  logic [15:0] out_red_o, out_green_o, out_blue_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hls_shade_color u_top (
    .clk_i, .rst_ni, .start, .busy, .in_red_i, .in_green_i, .in_blue_i,
    .done, .out_red_o, .out_green_o, .out_blue_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pixel_t      pending_px[$];
  pixel_t      shaded_px[$];
  logic [15:0] factor_q = SHADE_RESET;
  int unsigned mismatches = 0;
  int unsigned gap = 0;
  int unsigned quiet = 0;

  function automatic logic [63:0] scale_lsq(logic [63:0] v, logic [15:0] f);
    logic [63:0] r;
    r = (v * 64'(f) + 64'd2048) >> 12;
    return (r > 64'd65536) ? 64'd65536 : r;
  endfunction

  function automatic logic [15:0] ramp(logic [63:0] m1, logic [63:0] m2, logic [63:0] x);
    logic [63:0] acc, dv;
    dv = 64'd15360 << 32;
    if (x < 64'd15360) acc = m1 * 64'd15360 + (m2 - m1) * x;
    else if (x < 64'd46080) acc = m2 * 64'd15360;
    else if (x < 64'd61440) acc = m1 * 64'd15360 + (m2 - m1) * (64'd61440 - x);
    else acc = m1 * 64'd15360;
    return 16'((acc * FS + dv / 2) / dv);
  endfunction

  function automatic pixel_t shade_pixel(pixel_t p, logic [15:0] f);
    logic [63:0] r, g, b, mx, mn, sum, lq, sq, hq, d, den, m1, m2, hr, hb, v;
    longint t;
    pixel_t o;
    r = 64'(p.red); g = 64'(p.green); b = 64'(p.blue);
    mx = r; mn = r; sq = 64'd0; hq = 64'd0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    lq = (sum * 64'd65536 + FS) / (2 * FS);
    if (mx != mn) begin
      d = mx - mn;
      den = (sum <= FS) ? sum : (2 * FS - sum);
      sq = (d * 2 * 64'd65536 + den) / (2 * den);
      // sextant offset keeps t positive; red beats green beats blue on ties
      if (r == mx) t = longint'(6 * d) + longint'(g) - longint'(b);
      else if (g == mx) t = longint'(8 * d) + longint'(b) - longint'(r);
      else t = longint'(10 * d) + longint'(r) - longint'(g);
      hq = (2 * (64'(t) * 64'd15360) + d) / (2 * d);
      if (hq >= 64'd92160) hq -= 64'd92160;
    end
    lq = scale_lsq(lq, f);
    sq = scale_lsq(sq, f);
    if (sq == 64'd0) begin
      v = (lq * FS + 64'd32768) >> 16;
      o.red = v[15:0]; o.green = v[15:0]; o.blue = v[15:0];
    end else begin
      if (lq <= 64'd32768) m2 = lq * (64'd65536 + sq);
      else m2 = (lq + sq) * 64'd65536 - lq * sq;
      m1 = 2 * lq * 64'd65536 - m2;
      hr = hq + 64'd30720;
      if (hr >= 64'd92160) hr -= 64'd92160;
      hb = hq + 64'd61440;
      if (hb >= 64'd92160) hb -= 64'd92160;
      o.red = ramp(m1, m2, hr);
      o.green = ramp(m1, m2, hq);
      o.blue = ramp(m1, m2, hb);
    end
    return o;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int unsigned base;
    p = pixel_t'(48'({$urandom, $urandom}));
    case ($urandom_range(0, 5))
      0: begin
        p.green = p.red; p.blue = p.red;
      end
      1: begin
        base = $urandom_range(0, 65000);
        p.red = 16'(base + $urandom_range(0, 8));
        p.green = 16'(base + $urandom_range(0, 8));
        p.blue = 16'(base + $urandom_range(0, 8));
      end
      2: begin
        p.red = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
        p.blue = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
      end
      3: p.green = p.red;
      default: ;
    endcase
    return p;
  endfunction

  // driver: one transfer when start is high and busy is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        shaded_px.push_back(shade_pixel({in_red_i, in_green_i, in_blue_i}, factor_q));
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending_px.size() > 0) begin
          pixel_t p;
          p = pending_px.pop_front();
          in_red_i <= p.red;
          in_green_i <= p.green;
          in_blue_i <= p.blue;
          start <= 1'b1;
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      pixel_t exp_px;
      if (shaded_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h",
                                       out_red_o, out_green_o, out_blue_o);
      end else begin
        exp_px = shaded_px.pop_front();
        if (exp_px != {out_red_o, out_green_o, out_blue_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r/g/b %h %h %h got %h %h %h", exp_px.red,
                     exp_px.green, exp_px.blue, out_red_o, out_green_o, out_blue_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done || (psel && penable)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
        $display("[hls_shade_color] ERROR");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_W'(REG_SHADE_FACTOR)) factor_q = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_px.size() > 0 || start) @(posedge clk_i);
    while (shaded_px.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic push_directed();
    pending_px.push_back({16'h0000, 16'h0000, 16'h0000});
    pending_px.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_px.push_back({16'h8000, 16'h8000, 16'h8000});
    pending_px.push_back({16'hFFFF, 16'h0000, 16'h0000});
    pending_px.push_back({16'h0000, 16'hFFFF, 16'h0000});
    pending_px.push_back({16'h0000, 16'h0000, 16'hFFFF});
    pending_px.push_back({16'hFFFF, 16'hFFFF, 16'h0000});  // red/green tie
    pending_px.push_back({16'h0000, 16'hFFFF, 16'hFFFF});  // green/blue tie
    pending_px.push_back({16'hFFFF, 16'h0000, 16'hFFFF});  // red/blue tie
    pending_px.push_back({16'hFFFF, 16'h0000, 16'h0001});  // hue wraps near 360
    pending_px.push_back({16'h1234, 16'h0000, 16'h1233});
    pending_px.push_back({16'h0001, 16'h0000, 16'h0000});
    pending_px.push_back({16'hFFFE, 16'hFFFF, 16'hFFFF});
    pending_px.push_back({16'h5555, 16'hAAAA, 16'h0F0F});
    pending_px.push_back({16'h7FFF, 16'h8000, 16'h7FFF});
    pending_px.push_back({16'hC000, 16'h4000, 16'h8000});
  endtask

  initial begin
    logic [15:0] factors[6];
    factors = '{SHADE_RESET, 16'd0, 16'hFFFF, 16'd2048, 16'd6144, 16'd4097};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) apb_write(ADDR_W'(4), 16'h0123);  // no such register
      else if (ph > 0) apb_write(ADDR_W'(REG_SHADE_FACTOR), factors[ph]);
      push_directed();
      repeat (75) pending_px.push_back(rand_pixel());
      drain();
    end
    if (mismatches == 0 && shaded_px.size() == 0) begin
      $display("[hls_shade_color] OK");
    end else begin
      $display("[hls_shade_color] ERROR");
    end
    $finish;
  end

endmodule

// File: hls_shade_color.f
hdl/hsc_pkg.sv
hdl/hls_shade_color.sv
tb/sv/tb.sv
